### src/bayer_rggb_nearest_demosaic_unit_defines.svh
// Assertion macros for the Bayer RGGB nearest-neighbor demosaic unit.
`ifndef BAYER_RGGB_NEAREST_DEMOSAIC_UNIT_DEFINES_SVH
`define BAYER_RGGB_NEAREST_DEMOSAIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BRND_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("brnd: same-cycle check failed");
`define BRND_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("brnd: next-cycle check failed");
`else
`define BRND_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define BRND_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### src/brnd_pkg.sv
// Shared types and constants of the Bayer RGGB demosaic unit.
package brnd_pkg;

	localparam int RAW_BITS      = 16;
	localparam int DIM_BITS      = 13;
	localparam int GAIN_BITS     = 16;
	localparam int CH_BITS       = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef logic [RAW_BITS-1:0]      raw_t;
	typedef logic [DIM_BITS-1:0]      dim_t;
	typedef logic [GAIN_BITS-1:0]     gain_t;
	typedef logic [CH_BITS-1:0]       chan_t;
	typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
	typedef logic                     kind_t;

	localparam kind_t KIND_RAW   = 1'b0;
	localparam kind_t KIND_DRAIN = 1'b1;

	localparam cfg_idx_t CFG_IMAGE_WIDTH  = 3'd0;
	localparam cfg_idx_t CFG_IMAGE_HEIGHT = 3'd1;
	localparam cfg_idx_t CFG_GAIN_RED     = 3'd2;
	localparam cfg_idx_t CFG_GAIN_GREEN   = 3'd3;
	localparam cfg_idx_t CFG_GAIN_BLUE    = 3'd4;

	localparam dim_t DEFAULT_WIDTH  = 13'd1280;
	localparam dim_t DEFAULT_HEIGHT = 13'd2880;

	localparam int GAIN_RED_HUNDREDTHS   = 10;
	localparam int GAIN_GREEN_HUNDREDTHS = 11;
	localparam int GAIN_BLUE_HUNDREDTHS  = 13;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  end_of_row;
		logic  end_of_frame;
	} pix_t;

endpackage

### src/brnd_if.sv
// Channel interfaces: raw sample input, RGB pixel output, register writes.
interface brnd_in_if;
	logic             valid;
	logic             ready;
	brnd_pkg::kind_t  kind;
	brnd_pkg::raw_t   raw_sample;
	modport source (output valid, kind, raw_sample, input ready);
	modport sink   (input valid, kind, raw_sample, output ready);
endinterface

interface brnd_out_if;
	logic            valid;
	logic            ready;
	brnd_pkg::chan_t red;
	brnd_pkg::chan_t green;
	brnd_pkg::chan_t blue;
	logic            end_of_row;
	logic            end_of_frame;
	modport source (output valid, red, green, blue, end_of_row, end_of_frame, input ready);
	modport sink   (input valid, red, green, blue, end_of_row, end_of_frame, output ready);
endinterface

interface brnd_cfg_if;
	logic                valid;
	logic                ready;
	brnd_pkg::cfg_idx_t  index;
	brnd_pkg::cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### src/brnd_row_bank.sv
// One line store: single write port, two registered read ports.
module brnd_row_bank #(
	parameter int DEPTH     = 4096,
	parameter int DATA_BITS = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [DATA_BITS-1:0]       wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [DATA_BITS-1:0]       rdata_a,
	output logic [DATA_BITS-1:0]       rdata_b
);

	logic [DATA_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### src/bayer_rggb_nearest_demosaic_unit.sv
// Bayer RGGB nearest-neighbor demosaic with per-channel gain, top level.
//
// Raw samples arrive in raster order, one per clock while the unit is ready.
// Three line-store banks of MAX_WIDTH x SAMPLE_BITS rotate roles at each row
// end (current, previous, older); each bank has two read ports so every
// transaction reads both stored rows at two columns, and a one-column window
// register supplies the third. Pixels of row y-1 come out while row y is
// received; drain transactions emit the final row. Throughput is one
// transaction per clock while the queue has room, except the last sample
// of a row, which yields two pixels through the one-pixel-per-clock gain path
// and so holds the input until its second pixel is sent on. The stores are
// not cleared after reset; no clearing pass is needed before the first frame.
`include "bayer_rggb_nearest_demosaic_unit_defines.svh"

module bayer_rggb_nearest_demosaic_unit #(
	parameter int MAX_WIDTH          = 4096,
	parameter int SAMPLE_BITS        = 16,
	parameter int GAIN_FRACTION_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	brnd_cfg_if.sink   cfg,
	brnd_in_if.sink    raw,
	brnd_out_if.source rgb
);

	import brnd_pkg::*;

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int WW        = CW + 1;
	localparam int SB        = SAMPLE_BITS;
	localparam int PW        = SAMPLE_BITS + GAIN_BITS;
	localparam int NUM_BANKS = 3;

	localparam int DefGainRed   = ((GAIN_RED_HUNDREDTHS << GAIN_FRACTION_BITS) + 50) / 100;
	localparam int DefGainGreen = ((GAIN_GREEN_HUNDREDTHS << GAIN_FRACTION_BITS) + 50) / 100;
	localparam int DefGainBlue  = ((GAIN_BLUE_HUNDREDTHS << GAIN_FRACTION_BITS) + 50) / 100;

	localparam logic [PW:0] RoundBit = (PW+1)'(1) << (GAIN_FRACTION_BITS - 1);

	// registers
	dim_t  width_q, height_q;
	gain_t gain_r_q, gain_g_q, gain_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DEFAULT_WIDTH;
			height_q <= DEFAULT_HEIGHT;
			gain_r_q <= GAIN_BITS'(DefGainRed);
			gain_g_q <= GAIN_BITS'(DefGainGreen);
			gain_b_q <= GAIN_BITS'(DefGainBlue);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg.data[DIM_BITS-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg.data[DIM_BITS-1:0];
				CFG_GAIN_RED:     gain_r_q <= cfg.data;
				CFG_GAIN_GREEN:   gain_g_q <= cfg.data;
				CFG_GAIN_BLUE:    gain_b_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	dim_t          w13, h_eff;
	logic [WW-1:0] w_eff, wm1;
	gain_t         gain_r, gain_g, gain_b;

	assign w13    = (width_q == '0) ? DEFAULT_WIDTH : width_q;
	assign w_eff  = (32'(w13) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w13);
	assign wm1    = w_eff - WW'(1);
	assign h_eff  = (height_q == '0) ? DEFAULT_HEIGHT : height_q;
	assign gain_r = (gain_r_q == '0) ? GAIN_BITS'(DefGainRed)   : gain_r_q;
	assign gain_g = (gain_g_q == '0) ? GAIN_BITS'(DefGainGreen) : gain_g_q;
	assign gain_b = (gain_b_q == '0) ? GAIN_BITS'(DefGainBlue)  : gain_b_q;

	// frame position and bank roles
	logic [CW-1:0] col_q, drain_q;
	dim_t          row_q;
	logic [1:0]    cur_q, prev_q, old_q;

	logic          acc, is_drain, frame_in, x_last, d_last, raw_eff, drn_eff, item_eff;
	logic [WW-1:0] dp1;
	logic [CW-1:0] d_right, addr_a, addr_b;
	logic [1:0]    n_in;
	logic [SB-1:0] smp_in;

	assign acc      = raw.valid && raw.ready;
	assign is_drain = (raw.kind == KIND_DRAIN);
	assign frame_in = (row_q < h_eff);
	assign x_last   = (WW'(col_q) >= wm1);
	assign d_last   = (WW'(drain_q) >= wm1);
	assign raw_eff  = !is_drain && frame_in;
	assign drn_eff  = is_drain && !frame_in && (row_q != '0);
	assign item_eff = raw_eff || drn_eff;
	assign dp1      = WW'(drain_q) + WW'(1);
	assign d_right  = (dp1 > wm1) ? CW'(wm1) : CW'(dp1);
	assign smp_in   = raw.raw_sample[SB-1:0];

	always_comb begin
		if (is_drain) begin
			addr_a = d_right;
			addr_b = drain_q;
			n_in   = 2'd1;
		end else begin
			addr_a = col_q;
			addr_b = (col_q == '0) ? '0 : col_q - CW'(1);
			if (row_q == '0) begin
				n_in = 2'd0;
			end else begin
				n_in = 2'((col_q != '0)) + 2'(x_last);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			drain_q <= '0;
			row_q   <= '0;
			cur_q   <= 2'd0;
			prev_q  <= 2'd1;
			old_q   <= 2'd2;
		end else if (acc && raw_eff) begin
			if (x_last) begin
				col_q  <= '0;
				row_q  <= row_q + DIM_BITS'(1);
				cur_q  <= old_q;
				prev_q <= cur_q;
				old_q  <= prev_q;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end else if (acc && drn_eff) begin
			if (d_last) begin
				drain_q <= '0;
				row_q   <= '0;
				col_q   <= '0;
			end else begin
				drain_q <= drain_q + CW'(1);
			end
		end
	end

	// line stores
	logic [SB-1:0] rd_a [NUM_BANKS];
	logic [SB-1:0] rd_b [NUM_BANKS];

	for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
		brnd_row_bank #(
			.DEPTH     (MAX_WIDTH),
			.DATA_BITS (SB)
		) u_bank (
			.clk     (clk),
			.we      (acc && raw_eff && (cur_q == 2'(k))),
			.waddr   (col_q),
			.wdata   (smp_in),
			.re      (acc),
			.raddr_a (addr_a),
			.raddr_b (addr_b),
			.rdata_a (rd_a[k]),
			.rdata_b (rd_b[k])
		);
	end

	// stage 1: stored rows read, zero, one or two pixels to form
	logic          valid_s1, idx_s1;
	logic [1:0]    n_s1, prev_role_s1, old_role_s1;
	logic          lag_first_s1, par_lag_s1, x0_s1, lft_s1, lag_eor_s1, odd_row_s1, drain_s1;
	logic [SB-1:0] smp_s1;

	logic [SB-1:0] prev_b_q, old_b_q, smp_q;

	logic valid_s2, s2_go, last_px, s1_done, s1_send, s1_free;

	assign last_px   = (n_s1 != 2'd2) || idx_s1;
	assign s1_done   = s2_go && last_px;
	assign s1_send   = valid_s1 && (n_s1 != 2'd0) && s2_go;
	assign s1_free   = !valid_s1 || s1_done;
	assign raw.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= acc && item_eff;
			idx_s1   <= 1'b0;
		end else if (s1_send) begin
			idx_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			n_s1         <= is_drain ? 2'd1 : n_in;
			lag_first_s1 <= is_drain || (col_q != '0);
			par_lag_s1   <= is_drain ? drain_q[0] : !col_q[0];
			x0_s1        <= col_q[0];
			lft_s1       <= is_drain ? (drain_q == '0) : (col_q == CW'(1));
			lag_eor_s1   <= is_drain && d_last;
			odd_row_s1   <= !row_q[0];
			drain_s1     <= is_drain;
			smp_s1       <= smp_in;
			prev_role_s1 <= prev_q;
			old_role_s1  <= old_q;
		end
	end

	logic [SB-1:0] prev_a, prev_b, old_a, old_b;
	logic [SB-1:0] p_l, p_c, p_r, o_l, o_c, c_c, c_r;
	logic [SB-1:0] r_raw, g_raw, b_raw;
	logic          is_lag, odd_col, px_eor, px_eof;

	always_comb begin
		prev_a = rd_a[prev_role_s1];
		prev_b = rd_b[prev_role_s1];
		old_a  = rd_a[old_role_s1];
		old_b  = rd_b[old_role_s1];
		is_lag = lag_first_s1 && !idx_s1;
		if (is_lag) begin
			p_l     = lft_s1 ? prev_b : prev_b_q;
			p_c     = prev_b;
			p_r     = prev_a;
			o_l     = lft_s1 ? old_b : old_b_q;
			o_c     = old_b;
			c_c     = drain_s1 ? prev_b : smp_q;
			c_r     = drain_s1 ? prev_a : smp_s1;
			odd_col = par_lag_s1;
			px_eor  = lag_eor_s1;
			px_eof  = lag_eor_s1;
		end else begin
			p_l     = prev_b;
			p_c     = prev_a;
			p_r     = prev_a;
			o_l     = old_b;
			o_c     = old_a;
			c_c     = smp_s1;
			c_r     = smp_s1;
			odd_col = x0_s1;
			px_eor  = 1'b1;
			px_eof  = 1'b0;
		end
		case ({odd_row_s1, odd_col})
			2'b00: begin
				r_raw = p_c;
				g_raw = p_r;
				b_raw = c_r;
			end
			2'b01: begin
				r_raw = p_l;
				g_raw = p_c;
				b_raw = c_c;
			end
			2'b10: begin
				r_raw = o_c;
				g_raw = p_c;
				b_raw = p_r;
			end
			default: begin
				r_raw = o_l;
				g_raw = p_l;
				b_raw = p_c;
			end
		endcase
	end

	// one-column window, advanced as each transaction leaves stage 1
	always_ff @(posedge clk) begin
		if (valid_s1 && s1_done) begin
			prev_b_q <= prev_b;
			old_b_q  <= old_b;
			smp_q    <= smp_s1;
		end
	end

	// stage 2: gain products
	logic [PW-1:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic          eor_s2, eof_s2;
	logic [1:0]    cnt_q;

	assign s2_go = !valid_s2 || (cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_go) begin
			valid_s2 <= s1_send;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_send) begin
			prod_r_s2 <= PW'(r_raw) * PW'(gain_r);
			prod_g_s2 <= PW'(g_raw) * PW'(gain_g);
			prod_b_s2 <= PW'(b_raw) * PW'(gain_b);
			eor_s2    <= px_eor;
			eof_s2    <= px_eof;
		end
	end

	function automatic chan_t rnd_sat(input logic [PW-1:0] p);
		logic [PW:0] s;
		logic [PW:0] q;
		s = {1'b0, p} + RoundBit;
		q = s >> GAIN_FRACTION_BITS;
		return (q > (PW+1)'(255)) ? chan_t'(8'hFF) : CH_BITS'(q);
	endfunction

	// output queue, two entries
	pix_t e0_q, e1_q, pix_new;
	logic push, pop;

	assign pix_new = '{red: rnd_sat(prod_r_s2), green: rnd_sat(prod_g_s2),
		blue: rnd_sat(prod_b_s2), end_of_row: eor_s2, end_of_frame: eof_s2};
	assign push = valid_s2 && (cnt_q != 2'd2);
	assign pop  = rgb.valid && rgb.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				e0_q <= pix_new;
			end else begin
				e1_q <= pix_new;
			end
		end else if (pop && !push) begin
			e0_q <= e1_q;
		end else if (push && pop) begin
			e0_q <= pix_new;
		end
	end

	assign rgb.valid        = (cnt_q != 2'd0);
	assign rgb.red          = e0_q.red;
	assign rgb.green        = e0_q.green;
	assign rgb.blue         = e0_q.blue;
	assign rgb.end_of_row   = e0_q.end_of_row;
	assign rgb.end_of_frame = e0_q.end_of_frame;

	logic roles_ok;

	assign roles_ok = (cur_q != prev_q) && (prev_q != old_q) && (cur_q != old_q);

	`BRND_ASSERT_SAME(a_second_pixel, clk, arst_n, valid_s1 && idx_s1, n_s1 == 2'd2)
	`BRND_ASSERT_SAME(a_roles_distinct, clk, arst_n, 1'b1, roles_ok)
	`BRND_ASSERT_SAME(a_queue_bound, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`BRND_ASSERT_SAME(a_eof_ends_row, clk, arst_n, rgb.valid && rgb.end_of_frame, rgb.end_of_row)

endmodule

### sim/testbench.sv
// Self-checking testbench for the Bayer RGGB nearest-neighbor demosaic unit.
`timescale 1ns / 100ps

module testbench;
	import brnd_pkg::*;

	localparam int MAX_LINE      = 4096;
	localparam int GAIN_FRAC     = 12;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 1080;

	localparam gain_t DEF_GAIN_RED   = gain_t'(((GAIN_RED_HUNDREDTHS << GAIN_FRAC) + 50) / 100);
	localparam gain_t DEF_GAIN_GREEN = gain_t'(((GAIN_GREEN_HUNDREDTHS << GAIN_FRAC) + 50) / 100);
	localparam gain_t DEF_GAIN_BLUE  = gain_t'(((GAIN_BLUE_HUNDREDTHS << GAIN_FRAC) + 50) / 100);

	typedef struct packed {
		kind_t kind;
		raw_t  sample;
	} raw_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	brnd_cfg_if cfg();
	brnd_in_if  raw();
	brnd_out_if rgb();

	bayer_rggb_nearest_demosaic_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.raw(raw),
		.rgb(rgb)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	raw_item_t   sample_feed[$];
	pix_t        due_pixels[$];
	raw_item_t   on_bus;
	pix_t        want_px;
	int          errors = 0;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	int          src_gap = 0;
	int          snk_gap = 0;
	int unsigned cycle_count = 0;

	// line stores rotate roles at row end: current, previous, older
	bit [RAW_BITS-1:0] line_bank [3][MAX_LINE];
	int          cur_b = 0;
	int          prev_b = 1;
	int          old_b = 2;
	int unsigned col_cnt = 0;
	int unsigned row_cnt = 0;
	int unsigned drain_col = 0;

	dim_t  width_reg = DEFAULT_WIDTH;
	dim_t  height_reg = DEFAULT_HEIGHT;
	gain_t red_gain = DEF_GAIN_RED;
	gain_t green_gain = DEF_GAIN_GREEN;
	gain_t blue_gain = DEF_GAIN_BLUE;

	function automatic int unsigned active_width();
		int unsigned w;
		w = width_reg;
		if (w == 0) w = DEFAULT_WIDTH;
		if (w > MAX_LINE) w = MAX_LINE;
		return w;
	endfunction

	function automatic int unsigned active_height();
		return (height_reg == '0) ? DEFAULT_HEIGHT : height_reg;
	endfunction

	function automatic chan_t apply_gain(raw_t v, gain_t g, gain_t dflt);
		longint unsigned prod;
		prod = v;
		prod = (prod * ((g == '0) ? dflt : g) + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
		return (prod > 255) ? chan_t'(255) : chan_t'(prod);
	endfunction

	function automatic pix_t demosaic_pixel(int unsigned x, bit odd_row, int above_b, int here_b,
			int below_b, int unsigned w, bit eor, bit eof);
		int unsigned xr;
		int unsigned xl;
		raw_t r;
		raw_t g;
		raw_t b;
		pix_t p;
		xr = (x + 1 > w - 1) ? w - 1 : x + 1;
		xl = (x == 0) ? 0 : x - 1;
		case ({odd_row, x[0]})
			2'b00: begin
				r = line_bank[here_b][x];
				g = line_bank[here_b][xr];
				b = line_bank[below_b][xr];
			end
			2'b01: begin
				g = line_bank[here_b][x];
				r = line_bank[here_b][xl];
				b = line_bank[below_b][x];
			end
			2'b10: begin
				g = line_bank[here_b][x];
				r = line_bank[above_b][x];
				b = line_bank[here_b][xr];
			end
			default: begin
				b = line_bank[here_b][x];
				g = line_bank[here_b][xl];
				r = line_bank[above_b][xl];
			end
		endcase
		p.red = apply_gain(r, red_gain, DEF_GAIN_RED);
		p.green = apply_gain(g, green_gain, DEF_GAIN_GREEN);
		p.blue = apply_gain(b, blue_gain, DEF_GAIN_BLUE);
		p.end_of_row = eor;
		p.end_of_frame = eof;
		return p;
	endfunction

	function automatic void demosaic_step(raw_item_t it);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int t;
		bit last;
		bit odd;
		w = active_width();
		h = active_height();
		if (it.kind == KIND_RAW) begin
			if (row_cnt >= h) return;
			x = col_cnt;
			if (x >= MAX_LINE) x = MAX_LINE - 1;
			last = (x + 1 >= w);
			line_bank[cur_b][x] = it.sample;
			if (row_cnt >= 1) begin
				odd = ((row_cnt - 1) % 2) != 0;
				if (x >= 1)
					due_pixels.push_back(demosaic_pixel(x - 1, odd, old_b, prev_b, cur_b, w, 0, 0));
				if (last)
					due_pixels.push_back(demosaic_pixel(x, odd, old_b, prev_b, cur_b, w, 1, 0));
			end
			if (last) begin
				t = old_b;
				old_b = prev_b;
				prev_b = cur_b;
				cur_b = t;
				row_cnt = (row_cnt + 1) % 8192;
				col_cnt = 0;
			end else begin
				col_cnt = x + 1;
			end
		end else begin
			if (row_cnt < h || row_cnt == 0) return;
			x = drain_col;
			if (x >= MAX_LINE) x = MAX_LINE - 1;
			last = (x + 1 >= w);
			odd = ((row_cnt - 1) % 2) != 0;
			due_pixels.push_back(demosaic_pixel(x, odd, old_b, prev_b, prev_b, w, last, last));
			if (last) begin
				drain_col = 0;
				row_cnt = 0;
				col_cnt = 0;
			end else begin
				drain_col = x + 1;
			end
		end
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			raw.valid <= 1'b0;
		end else begin
			if (raw.valid && raw.ready)
				demosaic_step(on_bus);
			if (!raw.valid || raw.ready) begin
				if (src_gap != 0) begin
					src_gap--;
					raw.valid <= 1'b0;
				end else if (sample_feed.size() != 0) begin
					on_bus = sample_feed.pop_front();
					raw.valid <= 1'b1;
					raw.kind <= on_bus.kind;
					raw.raw_sample <= on_bus.sample;
					if ($urandom_range(0, 99) < src_idle_pct)
						src_gap = $urandom_range(1, 15);
				end else begin
					raw.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// pixel monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rgb.ready <= 1'b0;
		end else begin
			if (rgb.valid && rgb.ready) begin
				if (due_pixels.size() == 0) begin
					$display("%0t: pixel with none expected, actual r=%0d g=%0d b=%0d eor=%0b eof=%0b",
						$time, rgb.red, rgb.green, rgb.blue, rgb.end_of_row, rgb.end_of_frame);
					errors++;
				end else begin
					want_px = due_pixels.pop_front();
					check_field("red", want_px.red, rgb.red);
					check_field("green", want_px.green, rgb.green);
					check_field("blue", want_px.blue, rgb.blue);
					check_field("end_of_row", want_px.end_of_row, rgb.end_of_row);
					check_field("end_of_frame", want_px.end_of_frame, rgb.end_of_frame);
				end
			end
			if (snk_gap != 0) begin
				snk_gap--;
				rgb.ready <= 1'b0;
			end else begin
				rgb.ready <= 1'b1;
				if ($urandom_range(0, 99) < snk_idle_pct)
					snk_gap = $urandom_range(1, 15);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic raw_t pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return raw_t'($urandom_range(0, 2047));
			default: return raw_t'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic gain_t pick_gain();
		case ($urandom_range(0, 7))
			0, 1: return '0;
			2: return '1;
			3: return gain_t'($urandom_range(1, 63));
			4, 5: return gain_t'($urandom_range(64, 1024));
			default: return gain_t'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic feed_raw(raw_t s);
		sample_feed.push_back('{KIND_RAW, s});
	endtask

	task automatic feed_drain();
		sample_feed.push_back('{KIND_DRAIN, pick_sample()});
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_IMAGE_WIDTH:  width_reg = val[DIM_BITS-1:0];
			CFG_IMAGE_HEIGHT: height_reg = val[DIM_BITS-1:0];
			CFG_GAIN_RED:     red_gain = val;
			CFG_GAIN_GREEN:   green_gain = val;
			CFG_GAIN_BLUE:    blue_gain = val;
			default: ;
		endcase
	endtask

	task automatic write_gains(gain_t r, gain_t g, gain_t b);
		write_reg(CFG_GAIN_RED, r);
		write_reg(CFG_GAIN_GREEN, g);
		write_reg(CFG_GAIN_BLUE, b);
	endtask

	// block idle: every sample accepted, every pixel seen, pipeline settled
	task automatic wait_quiet();
		do @(negedge clk); while (sample_feed.size() != 0 || raw.valid || due_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_frame(int unsigned w, int unsigned h, bit noisy, bit split);
		int unsigned n;
		int unsigned early_at;
		n = w * h;
		early_at = noisy ? $urandom_range(0, n - 1) : n;
		for (int unsigned i = 0; i < n; i++) begin
			if (split && i == n / 2) begin
				wait_quiet();
				write_gains(pick_gain(), pick_gain(), pick_gain());
			end
			if (i == early_at)
				feed_drain();
			feed_raw(pick_sample());
		end
		// extra sample after the last row, before the drain
		if (noisy && $urandom_range(0, 1) == 1)
			feed_raw(pick_sample());
		repeat (w) feed_drain();
	endtask

	initial begin : stimulus
		int unsigned w;
		int unsigned h;
		int unsigned random_items;
		bit first_split;
		random_items = 0;
		first_split = 1'b1;
		cfg.valid = 1'b0;
		cfg.index = CFG_IMAGE_WIDTH;
		cfg.data = '0;
		raw.valid = 1'b0;
		raw.kind = KIND_RAW;
		raw.raw_sample = '0;
		rgb.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset gains first
		src_idle_pct = 20;
		snk_idle_pct = 20;
		write_reg(CFG_IMAGE_WIDTH, 16'd3);
		write_reg(CFG_IMAGE_HEIGHT, 16'd2);
		feed_drain();
		feed_raw(16'h0000);
		feed_raw(16'hFFFF);
		feed_raw(16'h5555);
		feed_drain();
		feed_raw(16'hAAAA);
		feed_raw(16'h00FF);
		feed_raw(16'hFF00);
		feed_raw(16'h1234);
		repeat (3) feed_drain();
		wait_quiet();
		write_gains(16'd0, 16'hFFFF, 16'd1);
		write_reg(CFG_IMAGE_WIDTH, 16'd1);
		write_reg(CFG_IMAGE_HEIGHT, 16'd1);
		feed_raw(16'hFFFF);
		feed_drain();
		feed_raw(16'h0800);
		feed_drain();
		wait_quiet();
		write_gains(16'd4096, 16'd2048, 16'd0);
		write_reg(CFG_IMAGE_WIDTH, 16'd2);
		write_reg(CFG_IMAGE_HEIGHT, 16'd3);
		feed_raw(16'd1);
		feed_raw(16'd3);
		feed_raw(16'd255);
		feed_raw(16'd256);
		feed_raw(16'd511);
		feed_raw(16'h7FFF);
		repeat (2) feed_drain();

		while (random_items < RANDOM_ITEMS) begin
			wait_quiet();
			src_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			snk_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			h = $urandom_range(1, 6);
			write_reg(CFG_IMAGE_WIDTH, cfg_data_t'(w));
			write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'(h));
			write_gains(pick_gain(), pick_gain(), pick_gain());
			repeat ($urandom_range(1, 3)) begin
				if (random_items < RANDOM_ITEMS) begin
					queue_frame(w, h, $urandom_range(0, 2) == 0,
						first_split || $urandom_range(0, 7) == 0);
					first_split = 1'b0;
					random_items += w * h + w;
				end
			end
		end

		// closing frame, no idling from here on
		wait_quiet();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_gains(16'd1, 16'd16, 16'd0);
		write_reg(CFG_IMAGE_WIDTH, 16'd48);
		write_reg(CFG_IMAGE_HEIGHT, 16'd4);
		queue_frame(48, 4, 1'b0, 1'b0);
		wait_quiet();

		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
